FILE: src/fbq_pkg.sv
// ----------------------------------------------------------------------------
// fbq_pkg
// Shared types and constants for the FIFO block queue with search.
// ----------------------------------------------------------------------------
package fbq_pkg;

  localparam int DEPTH      = 64;
  localparam int TAG_BITS   = 24;
  localparam int INDEX_BITS = 10;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ENTRY_W    = TAG_BITS + INDEX_BITS;

  localparam logic [2:0] MODE_ENQ      = 3'd0;
  localparam logic [2:0] MODE_POLL     = 3'd1;
  localparam logic [2:0] MODE_CONTAINS = 3'd2;
  localparam logic [2:0] MODE_FIND     = 3'd3;
  localparam logic [2:0] MODE_REMOVE   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]            mode;
    logic [TAG_BITS-1:0]   tag;
    logic [INDEX_BITS-1:0] index;
  } fbq_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic [TAG_BITS-1:0]   result_tag;
    logic [INDEX_BITS-1:0] result_index;
    logic [TAG_BITS-1:0]   head_tag;
    logic [INDEX_BITS-1:0] head_index;
    logic [CNT_W-1:0]      entry_count;
    logic                  is_empty;
  } fbq_out_t;

endpackage

FILE: src/fbq_ram.sv
// ----------------------------------------------------------------------------
// fbq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/fifo_block_queue_with_search_unit.sv
// ----------------------------------------------------------------------------
// fifo_block_queue_with_search_unit
// Ordered queue of cache block ids (tag, set index) with associative search.
// ----------------------------------------------------------------------------
// One item is taken when start is high and busy is low; its result shows on
// result_o for one cycle with done_o high, and must be taken then. Entries
// live in one RAM with a single read and a single write port, and every
// operation ends with a read of the head slot. Enqueue writes the item at the
// tail; poll advances the head and captures the entry it left; contains and
// find read the entries in order from the head until a match or the last
// entry; remove then shifts the later entries forward one slot. Enqueue, the
// unused modes and any operation on an empty queue go straight to the head
// read. busy is low again in the cycle that carries the result, so a new item
// can be taken in that cycle.
module fifo_block_queue_with_search_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  fbq_pkg::fbq_in_t item_i,
  output logic             done_o,
  output fbq_pkg::fbq_out_t result_o
);
  import fbq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POLL_CAP,
    S_SEARCH,
    S_SHIFT,
    S_HEAD_RD,
    S_HEAD_CAP
  } state_e;

  state_e                state_q;
  fbq_in_t               cmd_q;
  fbq_out_t              res_q;
  logic                  done_q;
  logic [PTR_W-1:0]      head_q;
  logic [CNT_W-1:0]      occ_q;
  logic [CNT_W-1:0]      rd_off_q;
  logic [CNT_W-1:0]      cmp_off_q;
  logic                  cmp_v_q;

  logic                  accept;
  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [PTR_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [TAG_BITS-1:0]   ent_tag;
  logic [INDEX_BITS-1:0] ent_idx;
  logic                  match;
  logic                  q_full;
  logic                  q_empty;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign done_o  = done_q;
  assign result_o = res_q;

  assign q_full  = (occ_q == CNT_W'(DEPTH));
  assign q_empty = (occ_q == '0);
  assign ent_tag = ram_rdata[ENTRY_W-1:INDEX_BITS];
  assign ent_idx = ram_rdata[INDEX_BITS-1:0];
  assign match   = (ent_idx == cmd_q.index) &&
                   ((cmd_q.mode == MODE_FIND) || (ent_tag == cmd_q.tag));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_q + occ_q[PTR_W-1:0];
    ram_wdata = {item_i.tag, item_i.index};
    ram_raddr = head_q;
    unique case (state_q)
      S_IDLE: begin
        ram_we = accept && (item_i.mode == MODE_ENQ) && !q_full;
      end
      S_SEARCH: begin
        ram_raddr = head_q + rd_off_q[PTR_W-1:0];
      end
      S_SHIFT: begin
        ram_raddr = head_q + rd_off_q[PTR_W-1:0];
        ram_we    = cmp_v_q;
        ram_waddr = head_q + cmp_off_q[PTR_W-1:0] - PTR_W'(1);
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_raddr = head_q;
      end
    endcase
  end

  fbq_ram #(
    .Width (ENTRY_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      head_q    <= '0;
      occ_q     <= '0;
      rd_off_q  <= '0;
      cmp_off_q <= '0;
      cmp_v_q   <= 1'b0;
      cmd_q     <= '0;
      res_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= item_i;
            res_q    <= '0;
            rd_off_q <= '0;
            cmp_v_q  <= 1'b0;
            if ((item_i.mode == MODE_POLL || item_i.mode == MODE_CONTAINS ||
                 item_i.mode == MODE_FIND || item_i.mode == MODE_REMOVE) && q_empty) begin
              res_q.status <= ST_EMPTY;
              state_q      <= S_HEAD_RD;
            end else begin
              unique case (item_i.mode)
                MODE_ENQ: begin
                  if (q_full) begin
                    res_q.status <= ST_FULL;
                  end else begin
                    occ_q <= occ_q + CNT_W'(1);
                  end
                  state_q <= S_HEAD_RD;
                end
                MODE_POLL: begin
                  head_q  <= head_q + PTR_W'(1);
                  occ_q   <= occ_q - CNT_W'(1);
                  state_q <= S_POLL_CAP;
                end
                MODE_CONTAINS, MODE_FIND, MODE_REMOVE: begin
                  state_q <= S_SEARCH;
                end
                default: begin
                  state_q <= S_HEAD_RD;
                end
              endcase
            end
          end
        end
        S_POLL_CAP: begin
          res_q.result_tag   <= ent_tag;
          res_q.result_index <= ent_idx;
          state_q            <= S_HEAD_RD;
        end
        S_SEARCH: begin
          if (rd_off_q < occ_q) begin
            rd_off_q  <= rd_off_q + CNT_W'(1);
            cmp_off_q <= rd_off_q;
            cmp_v_q   <= 1'b1;
          end else begin
            cmp_v_q <= 1'b0;
          end
          if (cmp_v_q) begin
            if (match) begin
              res_q.found <= 1'b1;
              if (cmd_q.mode == MODE_FIND) begin
                res_q.result_tag <= ent_tag;
              end
              if (cmd_q.mode == MODE_REMOVE) begin
                rd_off_q <= cmp_off_q + CNT_W'(1);
                cmp_v_q  <= 1'b0;
                state_q  <= S_SHIFT;
              end else begin
                state_q <= S_HEAD_RD;
              end
            end else if (cmp_off_q == occ_q - CNT_W'(1)) begin
              res_q.status <= ST_NOT_FOUND;
              state_q      <= S_HEAD_RD;
            end
          end
        end
        S_SHIFT: begin
          if (rd_off_q < occ_q) begin
            rd_off_q  <= rd_off_q + CNT_W'(1);
            cmp_off_q <= rd_off_q;
            cmp_v_q   <= 1'b1;
          end else begin
            cmp_v_q <= 1'b0;
            if (!cmp_v_q) begin
              occ_q   <= occ_q - CNT_W'(1);
              state_q <= S_HEAD_RD;
            end
          end
        end
        S_HEAD_RD: begin
          state_q <= S_HEAD_CAP;
        end
        S_HEAD_CAP: begin
          res_q.head_tag    <= q_empty ? '0 : ent_tag;
          res_q.head_index  <= q_empty ? '0 : ent_idx;
          res_q.entry_count <= occ_q;
          res_q.is_empty    <= q_empty;
          done_q            <= 1'b1;
          state_q           <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (accept || state_q == S_SHIFT))
    else $error("ram write outside enqueue or shift");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (res_q.is_empty == (res_q.entry_count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule
